// ===== hw/rtl/priority_task_dispatcher_assert.svh =====
// Assertion macros used by the dispatcher back end
`ifndef PRIORITY_TASK_DISPATCHER_ASSERT_SVH
`define PRIORITY_TASK_DISPATCHER_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define PTD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent
`define PTD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/ptd_pkg.sv =====
// Types and codes shared across the priority task dispatcher
`timescale 1ns / 1ps
package ptd_pkg;
    localparam logic OP_ADD      = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    localparam logic [1:0] ST_ADDED      = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_DISPATCHED = 2'd2;
    localparam logic [1:0] ST_EMPTY      = 2'd3;

    localparam int SEQ_W = 32;

    typedef struct packed {
        logic        opcode;
        logic [63:0] name_key;
        logic [7:0]  task_priority;
        logic [15:0] burst_length;
    } ptd_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] chosen_name;
        logic [7:0]  chosen_priority;
        logic [15:0] chosen_burst;
        logic [31:0] start_time;
        logic [31:0] finish_time;
        logic [15:0] switch_count;
        logic [6:0]  tasks_left;
    } ptd_result_t;

    // one table entry as held in the RAM
    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [15:0]      burst;
        logic [7:0]       prio;
        logic [63:0]      name;
    } ptd_entry_t;
endpackage

// ===== hw/rtl/priority_task_dispatcher.sv =====
// Top level of the priority task dispatcher
// Add: searches from slot 0 for the lowest free slot and writes the item there.
// Dispatch: scans the whole table RAM one entry a cycle and removes the best.
// One item is worked at a time; a two-beat queue keeps accepting meanwhile.
// Full/empty answers skip search and scan. Synchronous active-low reset empties the
// table, clears clock and switch count; no clearing pass is needed.
`timescale 1ns / 1ps
module priority_task_dispatcher
    import ptd_pkg::*;
#(
    parameter int MaxTasks = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [87:0]  s_tdata,  // name_key, task_priority, burst_length
    input  logic         s_tuser,  // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [175:0] m_tdata,  // chosen_name, chosen_priority, chosen_burst,
                                   // start_time, finish_time, switch_count, tasks_left
    output logic [1:0]   m_tuser   // status
);
    ptd_item_t   in_item, q_item;
    ptd_result_t res;
    logic        q_valid, q_ready;

    assign in_item.opcode        = s_tuser;
    assign in_item.name_key      = s_tdata[63:0];
    assign in_item.task_priority = s_tdata[71:64];
    assign in_item.burst_length  = s_tdata[87:72];

    ptd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    ptd_back #(.MaxTasks(MaxTasks)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (res)
    );

    assign m_tuser = res.status;
    assign m_tdata = {1'b0, res.tasks_left, res.switch_count, res.finish_time,
                      res.start_time, res.chosen_burst, res.chosen_priority,
                      res.chosen_name};
endmodule

// ===== hw/rtl/ptd_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module ptd_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== hw/rtl/ptd_front.sv =====
// Front end: accepts beats and holds them in a two-deep queue
`timescale 1ns / 1ps
module ptd_front
    import ptd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  ptd_item_t in_item,
    output logic      q_valid,
    input  logic      q_ready,
    output ptd_item_t q_item
);
    ptd_item_t slot_reg [2];
    logic      wr_ptr_reg, wr_ptr_next;
    logic      rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic      push, pop;

    assign in_ready = (fill_reg != 2'd2);
    assign q_valid  = (fill_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // payload store
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end
endmodule

// ===== hw/rtl/ptd_back.sv =====
// Back end: task table, selection scan and result register
`timescale 1ns / 1ps
module ptd_back
    import ptd_pkg::*;
#(
    parameter int MaxTasks = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  ptd_item_t   q_item,
    output logic        out_valid,
    input  logic        out_ready,
    output ptd_result_t out_result
);
`include "priority_task_dispatcher_assert.svh"

    localparam int IdxW = $clog2(MaxTasks);
    localparam int CntW = $clog2(MaxTasks + 1);
    localparam logic [IdxW-1:0] LastIdx = IdxW'(MaxTasks - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(MaxTasks);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIND  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [IdxW-1:0]     idx_reg, idx_next;
    logic [MaxTasks-1:0] valid_reg, valid_next;
    logic [CntW-1:0]     count_reg, count_next;
    logic [31:0]         clock_reg, clock_next;
    logic [15:0]         sw_reg, sw_next;
    logic [SEQ_W-1:0]    seq_reg, seq_next;
    logic                out_valid_reg, out_valid_next;
    ptd_result_t         res_reg, res_next;
    ptd_item_t           item_reg;

    // scan pipeline: rd_idx_reg is registered with the read, so it names the entry in ram_rdata
    logic                rd_live_reg, rd_live_next;
    logic [IdxW-1:0]     rd_idx_reg;
    logic                have_best_reg, have_best_next;
    logic [IdxW-1:0]     best_idx_reg, best_idx_next;
    ptd_entry_t          best_reg, best_next;

    logic       ram_we, ram_re;
    ptd_entry_t ram_wdata, ram_rdata;
    logic       cand_ok, cand_better;
    logic [32:0] fin_sum;
    logic [31:0] fin_time;
    logic        start;

    ptd_ram #(
        .Width ($bits(ptd_entry_t)),
        .Depth (MaxTasks)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign q_ready    = (state_reg == S_IDLE) && !out_valid_reg;
    assign start      = q_valid && q_ready;
    assign out_valid  = out_valid_reg;
    assign out_result = res_reg;

    assign ram_we    = (state_reg == S_FIND) && !valid_reg[idx_reg];
    assign ram_re    = (state_reg == S_SCAN);
    assign ram_wdata = '{seq: seq_reg, burst: item_reg.burst_length,
                         prio: item_reg.task_priority, name: item_reg.name_key};

    // ordering: lower priority number, then lower name, then newer add
    assign cand_ok = rd_live_reg && valid_reg[rd_idx_reg];
    always_comb begin
        if (ram_rdata.prio != best_reg.prio) begin
            cand_better = ram_rdata.prio < best_reg.prio;
        end else if (ram_rdata.name != best_reg.name) begin
            cand_better = ram_rdata.name < best_reg.name;
        end else begin
            cand_better = ram_rdata.seq > best_reg.seq;
        end
    end

    // saturating finish time
    assign fin_sum  = {1'b0, clock_reg} + {17'd0, best_reg.burst};
    assign fin_time = fin_sum[32] ? 32'hFFFF_FFFF : fin_sum[31:0];

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        valid_next     = valid_reg;
        count_next     = count_reg;
        clock_next     = clock_reg;
        sw_next        = sw_reg;
        seq_next       = seq_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_next       = res_reg;
        rd_live_next   = 1'b0;
        have_best_next = have_best_reg;
        best_idx_next  = best_idx_reg;
        best_next      = best_reg;

        if (cand_ok && (!have_best_reg || cand_better)) begin
            have_best_next = 1'b1;
            best_idx_next  = rd_idx_reg;
            best_next      = ram_rdata;
        end

        unique case (state_reg)
            S_IDLE: begin
                idx_next = '0;
                if (start) begin
                    res_next              = '0;
                    res_next.switch_count = sw_reg;
                    res_next.tasks_left   = 7'(count_reg);
                    if (q_item.opcode == OP_ADD) begin
                        if (count_reg == FullCnt) begin
                            res_next.status = ST_FULL;
                            out_valid_next  = 1'b1;
                        end else begin
                            state_next = S_FIND;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            res_next.status = ST_EMPTY;
                            out_valid_next  = 1'b1;
                        end else begin
                            have_best_next = 1'b0;
                            state_next     = S_SCAN;
                        end
                    end
                end
            end
            S_FIND: begin
                if (!valid_reg[idx_reg]) begin
                    valid_next[idx_reg] = 1'b1;
                    count_next          = count_reg + 1'b1;
                    seq_next            = seq_reg + 1'b1;
                    res_next.status     = ST_ADDED;
                    res_next.tasks_left = 7'(count_reg + 1'b1);
                    out_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_SCAN: begin
                rd_live_next = 1'b1;
                if (idx_reg == LastIdx) begin
                    state_next = S_DRAIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DRAIN: begin
                state_next = S_FIN;
            end
            S_FIN: begin
                valid_next[best_idx_reg] = 1'b0;
                count_next               = count_reg - 1'b1;
                clock_next               = fin_time;
                if (count_reg != CntW'(1) && sw_reg != 16'hFFFF) begin
                    sw_next = sw_reg + 16'd1;
                end
                res_next.status          = ST_DISPATCHED;
                res_next.chosen_name     = best_reg.name;
                res_next.chosen_priority = best_reg.prio;
                res_next.chosen_burst    = best_reg.burst;
                res_next.start_time      = clock_reg;
                res_next.finish_time     = fin_time;
                res_next.switch_count    = sw_next;
                res_next.tasks_left      = 7'(count_reg - 1'b1);
                out_valid_next           = 1'b1;
                state_next               = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            valid_reg     <= '0;
            count_reg     <= '0;
            clock_reg     <= '0;
            sw_reg        <= '0;
            seq_reg       <= '0;
            out_valid_reg <= 1'b0;
            rd_live_reg   <= 1'b0;
            have_best_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            clock_reg     <= clock_next;
            sw_reg        <= sw_next;
            seq_reg       <= seq_next;
            out_valid_reg <= out_valid_next;
            rd_live_reg   <= rd_live_next;
            have_best_reg <= have_best_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        res_reg      <= res_next;
        rd_idx_reg   <= idx_reg;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        if (start) begin
            item_reg <= q_item;
        end
    end

    `PTD_ASSERT_IMP(a_count_matches, aclk, aresetn, 1'b1, count_reg == CntW'($countones(valid_reg)))
    `PTD_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= FullCnt)
    `PTD_ASSERT_NEXT(a_fin_removes, aclk, aresetn, state_reg == S_FIN, count_reg == $past(count_reg) - 1'b1)
    `PTD_ASSERT_IMP(a_fin_has_best, aclk, aresetn, state_reg == S_FIN, have_best_reg)
endmodule
